/* rtl/core/afr_pkg.sv */
package afr_pkg;

  localparam int unsigned DataWidth  = 64;
  localparam int unsigned ShiftWidth = $clog2(DataWidth);
  localparam int unsigned HalfWidth  = DataWidth / 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_XOR = 4'd6,
    OP_NOT = 4'd7,
    OP_SHL = 4'd8,
    OP_SHR = 4'd9,
    OP_ASR = 4'd10,
    OP_ROL = 4'd11,
    OP_ROR = 4'd12
  } afr_op_e;

  typedef enum logic [2:0] {
    WM_8  = 3'd0,
    WM_16 = 3'd1,
    WM_24 = 3'd2,
    WM_32 = 3'd3
  } afr_mode_e;

  typedef struct packed {
    logic less;
    logic equal;
    logic greater;
    logic overflow;
    logic borrow;
    logic carry;
    logic sign;
    logic zero;
  } afr_flags_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } afr_cmd_t;

  typedef struct packed {
    logic iter_op;
  } afr_sts_t;

  function automatic logic [DataWidth-1:0] afr_width_mask(input logic [2:0] mode);
    logic [DataWidth-1:0] mask;
    mask = '1;
    unique case (afr_mode_e'(mode))
      WM_8:    mask = DataWidth'(64'h0000_0000_0000_00FF);
      WM_16:   mask = DataWidth'(64'h0000_0000_0000_FFFF);
      WM_24:   mask = DataWidth'(64'h0000_0000_00FF_FFFF);
      WM_32:   mask = DataWidth'(64'h0000_0000_FFFF_FFFF);
      default: mask = '1;
    endcase
    return mask;
  endfunction

endpackage

/* rtl/core/afr_in_if.sv */
interface afr_in_if;
  logic                           valid;
  logic                           ready;
  logic [3:0]                     opcode;
  logic [afr_pkg::DataWidth-1:0]  operand_a;
  logic [afr_pkg::DataWidth-1:0]  operand_b;
  logic [2:0]                     width_mode;

  modport source (output valid, opcode, operand_a, operand_b, width_mode, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, width_mode, output ready);
endinterface

/* rtl/core/afr_out_if.sv */
interface afr_out_if;
  logic                           valid;
  logic                           ready;
  logic [afr_pkg::DataWidth-1:0]  result;
  logic                           zero_flag;
  logic                           sign_flag;
  logic                           carry_flag;
  logic                           borrow_flag;
  logic                           overflow_flag;
  logic                           greater_flag;
  logic                           equal_flag;
  logic                           less_flag;

  modport source (
    output valid, result, zero_flag, sign_flag, carry_flag, borrow_flag,
           overflow_flag, greater_flag, equal_flag, less_flag,
    input  ready
  );
  modport sink (
    input  valid, result, zero_flag, sign_flag, carry_flag, borrow_flag,
           overflow_flag, greater_flag, equal_flag, less_flag,
    output ready
  );
endinterface

/* rtl/core/afr_ctrl.sv */
module afr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  afr_pkg::afr_sts_t sts_i,
  output afr_pkg::afr_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WAIT
  } state_e;

  state_e                          state_q;
  logic [afr_pkg::ShiftWidth-1:0]  cnt_q;
  logic                            out_valid_q;
  logic                            accept;
  logic                            last_step;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign last_step   = (cnt_q == '1);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept;
    cmd_o.step   = (state_q == ST_CALC);
    cmd_o.commit = (state_q == ST_WAIT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            state_q <= sts_i.iter_op ? ST_CALC : ST_WAIT;
          end
        end
        ST_CALC: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (cmd_o.commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/afr_dp.sv */
module afr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  afr_pkg::afr_cmd_t             cmd_i,
  output afr_pkg::afr_sts_t             sts_o,
  input  logic [3:0]                    opcode_i,
  input  logic [afr_pkg::DataWidth-1:0] operand_a_i,
  input  logic [afr_pkg::DataWidth-1:0] operand_b_i,
  input  logic [2:0]                    width_mode_i,
  output logic [afr_pkg::DataWidth-1:0] result_o,
  output afr_pkg::afr_flags_t           flags_o
);

  localparam int unsigned W = afr_pkg::DataWidth;

  logic [3:0]             op_q;
  logic [2:0]             mode_q;
  logic [W-1:0]           a_q;
  logic [W-1:0]           b_q;
  logic [W-1:0]           acc_q;
  logic [W-1:0]           quo_q;
  logic                   lt_q;
  logic                   gt_q;
  logic                   eq_q;
  logic                   sum_hi_q;
  logic [W-1:0]           res_q;
  afr_pkg::afr_flags_t    flags_q;

  logic [W-1:0]           in_sum;
  logic [W:0]             rem_sh;
  logic [W:0]             rem_diff;
  logic [afr_pkg::ShiftWidth-1:0] shamt;
  logic [2*W-1:0]         rol_w;
  logic [2*W-1:0]         ror_w;
  logic [W-1:0]           res_d;
  logic                   is_mul;
  logic                   is_div;
  afr_pkg::afr_flags_t    flags_d;

  assign in_sum = operand_a_i + operand_b_i;
  assign sts_o.iter_op = (afr_pkg::afr_op_e'(opcode_i) == afr_pkg::OP_MUL) ||
                         (afr_pkg::afr_op_e'(opcode_i) == afr_pkg::OP_DIV);

  assign is_mul   = (afr_pkg::afr_op_e'(op_q) == afr_pkg::OP_MUL);
  assign is_div   = (afr_pkg::afr_op_e'(op_q) == afr_pkg::OP_DIV);
  assign rem_sh   = {acc_q, quo_q[W-1]};
  assign rem_diff = rem_sh - {1'b0, b_q};

  assign shamt = b_q[afr_pkg::ShiftWidth-1:0];
  assign rol_w = {a_q, a_q} << shamt;
  assign ror_w = {a_q, a_q} >> shamt;

  always_comb begin
    case (afr_pkg::afr_op_e'(op_q))
      afr_pkg::OP_ADD: res_d = a_q + b_q;
      afr_pkg::OP_SUB: res_d = a_q - b_q;
      afr_pkg::OP_MUL: res_d = acc_q;
      afr_pkg::OP_DIV: res_d = (b_q == '0) ? '0 : quo_q;
      afr_pkg::OP_AND: res_d = a_q & b_q;
      afr_pkg::OP_OR:  res_d = a_q | b_q;
      afr_pkg::OP_XOR: res_d = a_q ^ b_q;
      afr_pkg::OP_NOT: res_d = ~a_q;
      afr_pkg::OP_SHL: res_d = a_q << shamt;
      afr_pkg::OP_SHR: res_d = a_q >> shamt;
      afr_pkg::OP_ASR: res_d = W'($signed(a_q) >>> shamt);
      afr_pkg::OP_ROL: res_d = rol_w[2*W-1:W];
      afr_pkg::OP_ROR: res_d = ror_w[W-1:0];
      default:         res_d = a_q;
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (op_q <= 4'(afr_pkg::OP_ROR)) begin
      flags_d.zero     = (res_d == '0);
      flags_d.sign     = res_d[7];
      flags_d.overflow = 1'b0;
      if (op_q < 4'(afr_pkg::OP_SHL)) begin
        if (afr_pkg::afr_op_e'(op_q) == afr_pkg::OP_SUB) begin
          flags_d.carry  = lt_q;
          flags_d.borrow = lt_q;
        end else begin
          flags_d.carry  = sum_hi_q;
        end
        flags_d.greater = gt_q;
        flags_d.equal   = eq_q;
        flags_d.less    = lt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      mode_q   <= width_mode_i;
      a_q      <= operand_a_i;
      b_q      <= operand_b_i;
      acc_q    <= '0;
      quo_q    <= operand_a_i;
      lt_q     <= operand_a_i < operand_b_i;
      gt_q     <= operand_a_i > operand_b_i;
      eq_q     <= operand_a_i == operand_b_i;
      sum_hi_q <= |in_sum[W-1:afr_pkg::HalfWidth];
    end else if (cmd_i.step) begin
      if (is_mul) begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q <= a_q << 1;
        b_q <= b_q >> 1;
      end else if (is_div) begin
        if (!rem_diff[W]) begin
          acc_q <= rem_diff[W-1:0];
        end else begin
          acc_q <= rem_sh[W-1:0];
        end
        quo_q <= {quo_q[W-2:0], ~rem_diff[W]};
      end
    end
    if (cmd_i.commit) begin
      res_q <= (op_q <= 4'(afr_pkg::OP_ROR)) ? (res_d & afr_pkg::afr_width_mask(mode_q))
                                            : a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (cmd_i.commit) begin
      flags_q <= flags_d;
    end
  end

  assign result_o = res_q;
  assign flags_o  = flags_q;

endmodule

/* rtl/core/alu_with_flag_register_unit.sv */
// Channel  Direction  Handshake      Transaction carries
// in_i     sink       valid / ready  opcode, operand_a, operand_b, width_mode
// out_o    source     valid / ready  result and the eight kept flags
//
// Multiply and divide take 64 iterations of a shift-add or restoring-subtract
// step in the datapath before the result register is written; all other
// operations go from accept straight to the wait for the result register.
// One operation is in flight at a time; the result register holds a finished
// transaction while out_o stalls, and the next operation is accepted meanwhile.
// Reset clears the flag register and the controller; no result is pending.
module alu_with_flag_register_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  afr_in_if.sink    in_i,
  afr_out_if.source out_o
);

  afr_pkg::afr_cmd_t                cmd;
  afr_pkg::afr_sts_t                sts;
  afr_pkg::afr_flags_t              flags;
  logic [afr_pkg::DataWidth-1:0]    result;

  afr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  afr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (in_i.opcode),
    .operand_a_i  (in_i.operand_a),
    .operand_b_i  (in_i.operand_b),
    .width_mode_i (in_i.width_mode),
    .result_o     (result),
    .flags_o      (flags)
  );

  assign out_o.result        = result;
  assign out_o.zero_flag     = flags.zero;
  assign out_o.sign_flag     = flags.sign;
  assign out_o.carry_flag    = flags.carry;
  assign out_o.borrow_flag   = flags.borrow;
  assign out_o.overflow_flag = flags.overflow;
  assign out_o.greater_flag  = flags.greater;
  assign out_o.equal_flag    = flags.equal;
  assign out_o.less_flag     = flags.less;

endmodule

/* bench/alu_with_flag_register_unit_test.sv */
`timescale 1ns / 1ps

import afr_pkg::*;

typedef struct packed {
  logic [DataWidth-1:0] result;
  afr_flags_t           flags;
} alu_outcome_t;

class flag_alu_tracker;
  afr_flags_t   kept_flags;
  alu_outcome_t pending_outcomes[$];
  int           mismatches;

  function new();
    kept_flags = '0;
    mismatches = 0;
  endfunction

  function void note_operation(input logic [3:0] op, input logic [DataWidth-1:0] a,
                               input logic [DataWidth-1:0] b, input logic [2:0] mode);
    logic [DataWidth-1:0] value;
    logic [DataWidth-1:0] sum;
    logic [DataWidth-1:0] mask;
    logic [ShiftWidth-1:0] count;
    alu_outcome_t outcome;
    value = '0;
    sum   = a + b;
    count = b[ShiftWidth-1:0];
    case (op)
      OP_ADD: value = sum;
      OP_SUB: value = a - b;
      OP_MUL: value = a * b;
      OP_DIV: value = (b != 0) ? a / b : '0;
      OP_AND: value = a & b;
      OP_OR:  value = a | b;
      OP_XOR: value = a ^ b;
      OP_NOT: value = ~a;
      OP_SHL: value = a << count;
      OP_SHR: value = a >> count;
      OP_ASR: value = $signed(a) >>> count;
      OP_ROL: value = (a << count) | (a >> (DataWidth - int'(count)));
      OP_ROR: value = (a >> count) | (a << (DataWidth - int'(count)));
      default: value = '0;
    endcase
    case (mode)
      WM_8:    mask = 64'h0000_0000_0000_00FF;
      WM_16:   mask = 64'h0000_0000_0000_FFFF;
      WM_24:   mask = 64'h0000_0000_00FF_FFFF;
      WM_32:   mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = '1;
    endcase
    if (op <= OP_ROR) begin
      kept_flags.zero     = (value == '0);
      kept_flags.sign     = value[7];
      kept_flags.overflow = 1'b0;
      if (op < OP_SHL) begin
        if (op == OP_SUB) begin
          kept_flags.carry  = (a < b);
          kept_flags.borrow = (a < b);
        end else begin
          kept_flags.carry = |sum[DataWidth-1:HalfWidth];
        end
        kept_flags.greater = (a > b);
        kept_flags.equal   = (a == b);
        kept_flags.less    = (a < b);
      end
      outcome.result = value & mask;
    end else begin
      outcome.result = a;
    end
    outcome.flags = kept_flags;
    pending_outcomes.push_back(outcome);
  endfunction

  function void compare_field(input string name, input logic [DataWidth-1:0] want,
                              input logic [DataWidth-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_outcome(input alu_outcome_t actual);
    alu_outcome_t want;
    if (pending_outcomes.size() == 0) begin
      $error("result %0h arrived with no transaction outstanding", actual.result);
      mismatches++;
      return;
    end
    want = pending_outcomes.pop_front();
    compare_field("result",        want.result,         actual.result);
    compare_field("zero_flag",     DataWidth'(want.flags.zero),
                  DataWidth'(actual.flags.zero));
    compare_field("sign_flag",     DataWidth'(want.flags.sign),
                  DataWidth'(actual.flags.sign));
    compare_field("carry_flag",    DataWidth'(want.flags.carry),
                  DataWidth'(actual.flags.carry));
    compare_field("borrow_flag",   DataWidth'(want.flags.borrow),
                  DataWidth'(actual.flags.borrow));
    compare_field("overflow_flag", DataWidth'(want.flags.overflow),
                  DataWidth'(actual.flags.overflow));
    compare_field("greater_flag",  DataWidth'(want.flags.greater),
                  DataWidth'(actual.flags.greater));
    compare_field("equal_flag",    DataWidth'(want.flags.equal),
                  DataWidth'(actual.flags.equal));
    compare_field("less_flag",     DataWidth'(want.flags.less),
                  DataWidth'(actual.flags.less));
  endfunction
endclass

module alu_with_flag_register_unit_test;

  localparam logic [3:0] OP_PASS_LO  = 4'd13;
  localparam logic [3:0] OP_PASS_MID = 4'd14;
  localparam logic [3:0] OP_PASS_HI  = 4'd15;
  localparam logic [2:0] WM_64       = 3'd4;
  localparam logic [2:0] WM_64_ALT   = 3'd5;
  localparam logic [2:0] WM_64_SIX   = 3'd6;
  localparam logic [2:0] WM_64_SEVEN = 3'd7;
  localparam int         RandomOps   = 1850;
  localparam int         DrainCycles = 80;

  logic clk;
  logic rst_n;
  int   issued;

  flag_alu_tracker tracker;

  afr_in_if  in_if ();
  afr_out_if out_if ();

  alu_with_flag_register_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if ((issued % 256) < 48) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DataWidth-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DataWidth'($urandom_range(0, 255));
      3: return 64'd1 << $urandom_range(0, DataWidth - 1);
      4: return {32'h0, 32'($urandom)};
      5: return 64'h0000_0000_FFFF_FFFF - DataWidth'($urandom_range(0, 3));
      6: return {1'b1, 31'($urandom), 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic issue_op(input logic [3:0] op, input logic [DataWidth-1:0] a,
                          input logic [DataWidth-1:0] b, input logic [2:0] mode);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.operand_a  <= a;
    in_if.operand_b  <= b;
    in_if.width_mode <= mode;
    do @(posedge clk); while (!in_if.ready);
    tracker.note_operation(op, a, b, mode);
    issued++;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    alu_outcome_t seen;
    int           hold;
    logic         next_ready;
    hold = 0;
    next_ready = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        seen.result = out_if.result;
        seen.flags  = {out_if.less_flag, out_if.equal_flag, out_if.greater_flag,
                       out_if.overflow_flag, out_if.borrow_flag, out_if.carry_flag,
                       out_if.sign_flag, out_if.zero_flag};
        tracker.check_outcome(seen);
      end
      if (hold == 0) begin
        case ($urandom_range(0, 9))
          0:       begin next_ready = 1'b1; hold = $urandom_range(50, 200); end
          1:       begin next_ready = 1'b0; hold = $urandom_range(10, 40); end
          2, 3, 4: begin next_ready = 1'b0; hold = $urandom_range(1, 3); end
          default: begin next_ready = 1'b1; hold = $urandom_range(1, 8); end
        endcase
      end
      out_if.ready <= next_ready;
      hold--;
    end
  end

  initial begin
    logic [3:0]           op;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    tracker = new();
    issued = 0;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= '0;
    in_if.operand_a  <= '0;
    in_if.operand_b  <= '0;
    in_if.width_mode <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_op(OP_PASS_LO, 64'hDEAD_BEEF_0123_4567, 64'h1, WM_8);
    issue_op(OP_ADD,  '1, 64'd1, WM_64);
    issue_op(OP_ADD,  '0, '0, WM_8);
    issue_op(OP_ADD,  64'h0000_0000_FFFF_FFFF, 64'd1, WM_32);
    issue_op(OP_SUB,  '0, 64'd1, WM_32);
    issue_op(OP_SUB,  64'd5, 64'd5, WM_16);
    issue_op(OP_PASS_MID, '1, '0, WM_24);
    issue_op(OP_MUL,  '1, '1, WM_64_ALT);
    issue_op(OP_DIV,  64'd123, '0, WM_64);
    issue_op(OP_DIV,  '1, 64'd3, WM_24);
    issue_op(OP_AND,  64'hF0F0_F0F0_F0F0_F0F0, 64'hFF00_FF00_FF00_FF00, WM_16);
    issue_op(OP_OR,   64'h8000_0000_0000_0000, 64'h80, WM_64_SIX);
    issue_op(OP_XOR,  '1, '1, WM_64_SEVEN);
    issue_op(OP_NOT,  '0, '1, WM_8);
    issue_op(OP_SHL,  64'h1, 64'd67, WM_64);
    issue_op(OP_SHR,  '1, 64'd63, WM_64);
    issue_op(OP_ASR,  64'h8000_0000_0000_0010, 64'd4, WM_64);
    issue_op(OP_ASR,  64'h7000_0000_0000_0000, 64'd60, WM_32);
    issue_op(OP_ASR,  64'h8000_0000_0000_0000, '0, WM_64);
    issue_op(OP_ROL,  64'h8000_0000_0000_0001, '0, WM_64);
    issue_op(OP_ROL,  64'h8000_0000_0000_0001, 64'd1, WM_64);
    issue_op(OP_ROR,  64'h0000_0000_0000_0001, 64'd63, WM_8);
    issue_op(OP_PASS_HI, '0, '1, WM_64);

    repeat (RandomOps) begin
      op = 4'($urandom_range(0, 15));
      a  = pick_operand();
      case ($urandom_range(0, 19))
        0, 1, 2: b = a;
        3:       b = a + 64'd1;
        4:       b = a - 64'd1;
        default: b = pick_operand();
      endcase
      issue_op(op, a, b, 3'($urandom_range(WM_8, WM_64_ALT)));
    end
    in_if.valid <= 1'b0;

    while (tracker.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
